// ===== hdl/spi_eeprom_write_behind_controller_core_macros.svh =====
// assertion macros for the write-behind controller
`ifndef SPI_EEPROM_WRITE_BEHIND_CONTROLLER_CORE_MACROS_SVH
`define SPI_EEPROM_WRITE_BEHIND_CONTROLLER_CORE_MACROS_SVH
// assert that a condition implies a consequence on the same edge
`define SEWB_ASSERT_IMP(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("violation");
// assert that a condition implies a consequence on the next edge
`define SEWB_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("violation");
`endif

// ===== hdl/sewb_pkg.sv =====
// shared types and constants for the write-behind controller
`timescale 1ns / 1ps
`default_nettype none
package sewb_pkg;
	localparam int MEM_BYTES_DEF = 1024;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam logic [2:0] CMD_READ = 3'd0;
	localparam logic [2:0] CMD_WRITE = 3'd1;
	localparam logic [2:0] CMD_TICK = 3'd2;
	localparam logic [2:0] CMD_DONE = 3'd3;
	localparam logic [2:0] CMD_PRELOAD = 3'd4;
	localparam logic [1:0] KIND_RDATA = 2'd0;
	localparam logic [1:0] KIND_SPI = 2'd1;
	localparam logic [1:0] KIND_ACK = 2'd2;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [7:0] OP_WREN = 8'h06;
	localparam logic [7:0] OP_WRITE = 8'h02;
	localparam logic [7:0] OP_RDSR = 8'h05;
	localparam logic [7:0] WIP_MASK = 8'h01;
	localparam logic [15:0] ADDR_HI_MASK = 16'hFF00;

	// one work item handed from the front end to the back end
	typedef enum logic [2:0] {
		OPK_RESULT = 3'b001,  // single result, given whole
		OPK_READ   = 3'b010,  // read shadow bytes
		OPK_FRAME  = 3'b100   // write frame from job
	} opk_t;

	typedef struct packed {
		opk_t        opk;
		logic [1:0]  kind;
		logic [7:0]  spi_byte;
		logic        frame_end;
		logic [1:0]  status;
		logic        last;
		logic [15:0] addr;
		logic [2:0]  size;
	} work_t;
endpackage
`default_nettype wire

// ===== hdl/sewb_front.sv =====
// front end: decodes transactions, updates shadow and job queue, issues work
`timescale 1ns / 1ps
`default_nettype none
module sewb_front #(
	parameter int MEM_BYTES = sewb_pkg::MEM_BYTES_DEF,
	parameter int QUEUE_DEPTH = sewb_pkg::QUEUE_DEPTH_DEF,
	parameter int AW = $clog2(MEM_BYTES)
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic full,
	input  wire logic [2:0] cmd,
	input  wire logic [9:0] addr,
	input  wire logic [2:0] size,
	input  wire logic [31:0] wdata,
	input  wire logic [7:0] status_in,
	output logic wr_en,
	output logic [AW-1:0] wr_addr,
	output logic [7:0] wr_data,
	output logic wq_push,
	output sewb_pkg::work_t wq_data,
	input  wire logic wq_full,
	input  wire logic wq_busy,
	input  wire logic back_busy
);
	import sewb_pkg::*;
	localparam int QW = $clog2(QUEUE_DEPTH);

	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001, PH_WREN = 5'b00010, PH_WRITE = 5'b00100,
		PH_WAIT = 5'b01000, PH_POLL = 5'b10000
	} phase_t;

	typedef enum logic [1:0] {FS_DECODE = 2'b01, FS_WBYTES = 2'b10} fs_t;

	phase_t phase_q;
	fs_t fs_q;
	logic [QW:0] head_q, tail_q;
	logic [AW-1:0] job_addr [QUEUE_DEPTH];
	logic [2:0] job_size [QUEUE_DEPTH];
	logic [AW-1:0] waddr_q;
	logic [31:0] wdata_q;
	logic [2:0] wcnt_q;

	logic [16:0] end_addr;
	logic size_ok, fits, q_full, q_empty;
	logic go;

	// ring counters run modulo twice the depth
	function automatic logic [QW:0] ring_inc(input logic [QW:0] p);
		return (p == (QW+1)'(2 * QUEUE_DEPTH - 1)) ? '0 : p + (QW+1)'(1);
	endfunction

	function automatic logic [QW-1:0] ring_slot(input logic [QW:0] p);
		return (p >= (QW+1)'(QUEUE_DEPTH)) ? QW'(p - (QW+1)'(QUEUE_DEPTH)) : p[QW-1:0];
	endfunction

	assign end_addr = 17'(addr) + 17'(size);
	assign size_ok = (size == 3'd1) || (size == 3'd2) || (size == 3'd4);
	assign fits = size_ok && (end_addr <= 17'(MEM_BYTES));
	assign q_full = (ring_slot(head_q) == ring_slot(tail_q)) && (head_q != tail_q);
	assign q_empty = (head_q == tail_q);
	// hold input while shadow reads are pending so shadow writes cannot overtake them
	assign full = (fs_q != FS_DECODE) || wq_full || wq_busy || back_busy;
	assign go = push && !full;

	// shadow byte writes, one per cycle
	always_comb begin
		wr_en = 1'b0;
		wr_addr = waddr_q;
		wr_data = wdata_q[7:0];
		if (fs_q == FS_WBYTES) begin
			wr_en = 1'b1;
			wr_data = wdata_q[8*wcnt_q-1 -: 8];
		end else if (go && cmd == CMD_PRELOAD && 17'(addr) < 17'(MEM_BYTES)) begin
			wr_en = 1'b1;
			wr_addr = AW'(addr);
			wr_data = wdata[7:0];
		end
	end

	always_comb begin
		wq_push = 1'b0;
		wq_data = '0;
		wq_data.opk = OPK_RESULT;
		wq_data.last = 1'b1;
		wq_data.addr = 16'(addr);
		wq_data.size = size;
		if (go) begin
			unique case (cmd)
				CMD_READ: begin
					wq_push = 1'b1;
					wq_data.kind = KIND_RDATA;
					if (fits) wq_data.opk = OPK_READ;
					else wq_data.status = ST_RANGE;
				end
				CMD_WRITE: begin
					wq_push = 1'b1;
					wq_data.kind = KIND_ACK;
					wq_data.status = !fits ? ST_RANGE : (q_full ? ST_FULL : ST_OK);
				end
				CMD_PRELOAD: begin
					wq_push = 1'b1;
					wq_data.kind = KIND_ACK;
					wq_data.status = (17'(addr) < 17'(MEM_BYTES)) ? ST_OK : ST_RANGE;
				end
				CMD_TICK: begin
					wq_data.kind = KIND_SPI;
					if (phase_q == PH_IDLE && !q_empty) begin
						wq_push = 1'b1;
						wq_data.spi_byte = OP_WREN;
						wq_data.frame_end = 1'b1;
					end else if (phase_q == PH_WAIT) begin
						wq_push = 1'b1;
						wq_data.spi_byte = OP_RDSR;
						wq_data.last = 1'b0;
						wq_data.opk = OPK_READ;  // poll pair, see back end
						wq_data.size = 3'd0;
					end
				end
				CMD_DONE: begin
					if (phase_q == PH_WREN) begin
						wq_push = 1'b1;
						wq_data.kind = KIND_SPI;
						wq_data.opk = OPK_FRAME;
						wq_data.addr = 16'(job_addr[ring_slot(tail_q)]);
						wq_data.size = job_size[ring_slot(tail_q)];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			fs_q <= FS_DECODE;
			head_q <= '0;
			tail_q <= '0;
		end else if (fs_q == FS_WBYTES) begin
			waddr_q <= waddr_q + AW'(1);
			wcnt_q <= wcnt_q - 3'd1;
			if (wcnt_q == 3'd1) fs_q <= FS_DECODE;
		end else if (go) begin
			unique case (cmd)
				CMD_WRITE: if (fits) begin
					fs_q <= FS_WBYTES;
					waddr_q <= AW'(addr);
					wdata_q <= wdata;
					wcnt_q <= size;
					if (!q_full) head_q <= ring_inc(head_q);
				end
				CMD_TICK: begin
					if (phase_q == PH_IDLE && !q_empty) phase_q <= PH_WREN;
					else if (phase_q == PH_WAIT) phase_q <= PH_POLL;
				end
				CMD_DONE: begin
					if (phase_q == PH_WREN) phase_q <= PH_WRITE;
					else if (phase_q == PH_WRITE) phase_q <= PH_WAIT;
					else if (phase_q == PH_POLL) begin
						if ((status_in & WIP_MASK) == 8'd0) begin
							phase_q <= PH_IDLE;
							tail_q <= ring_inc(tail_q);
						end else phase_q <= PH_WAIT;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (go && cmd == CMD_WRITE && fits && !q_full) begin
			job_addr[ring_slot(head_q)] <= AW'(addr);
			job_size[ring_slot(head_q)] <= size;
		end
	end
endmodule
`default_nettype wire

// ===== hdl/sewb_wq.sv =====
// short work queue between front and back end
`timescale 1ns / 1ps
`default_nettype none
module sewb_wq #(
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_push,
	input  sewb_pkg::work_t in_data,
	output logic in_full,
	output logic out_valid,
	output sewb_pkg::work_t out_data,
	input  wire logic out_pop
);
	import sewb_pkg::*;
	localparam int PW = $clog2(DEPTH);
	work_t mem_q [DEPTH];
	logic [PW:0] wp_q, rp_q;

	assign in_full = ((wp_q - rp_q) == (PW+1)'(DEPTH));
	assign out_valid = (wp_q != rp_q);
	assign out_data = mem_q[rp_q[PW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (in_push && !in_full) wp_q <= wp_q + (PW+1)'(1);
			if (out_pop && out_valid) rp_q <= rp_q + (PW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_push && !in_full) mem_q[wp_q[PW-1:0]] <= in_data;
	end
endmodule
`default_nettype wire

// ===== hdl/sewb_back.sv =====
// back end: shadow memory, read assembly and spi frame sequencing
`timescale 1ns / 1ps
`default_nettype none
module sewb_back #(
	parameter int MEM_BYTES = sewb_pkg::MEM_BYTES_DEF,
	parameter int AW = $clog2(MEM_BYTES)
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [7:0] wr_data,
	input  wire logic wq_valid,
	input  sewb_pkg::work_t wq_data,
	output logic wq_pop,
	output logic rd_busy,
	output logic empty,
	input  wire logic pop,
	output logic [1:0] kind,
	output logic [31:0] rdata,
	output logic [7:0] spi_byte,
	output logic frame_end,
	output logic [1:0] status,
	output logic last
);
	import sewb_pkg::*;

	typedef enum logic [3:0] {
		BS_IDLE = 4'b0001, BS_READ = 4'b0010, BS_FRAME = 4'b0100, BS_OUT = 4'b1000
	} bs_t;

	logic [7:0] shadow_mem [MEM_BYTES];
	logic [7:0] rd_q;
	bs_t bs_q;
	work_t w_q;
	logic [2:0] step_q;   // frame step or bytes issued
	logic [2:0] got_q;    // read bytes collected
	logic rd_pend_q;
	logic [15:0] ix;
	logic ix_in;
	logic [31:0] acc_q;
	logic ov_q;           // output register holds a result
	logic [7:0] sb_n;
	logic fe_n, last_n, emit, fire;

	assign empty = !ov_q;
	assign ix = w_q.addr + 16'(got_q);
	assign ix_in = ({1'b0, ix} < 17'(MEM_BYTES));
	assign wq_pop = (bs_q == BS_IDLE) && wq_valid;
	assign rd_busy = (bs_q == BS_READ) || (bs_q == BS_FRAME);

	always_ff @(posedge clk) begin
		if (wr_en) shadow_mem[wr_addr] <= wr_data;
		rd_q <= shadow_mem[ix[AW-1:0]];
	end

	// frame byte for the current step; step 0..2 header, then data bytes
	always_comb begin
		sb_n = 8'd0;
		fe_n = 1'b0;
		last_n = 1'b0;
		unique case (step_q)
			3'd0: sb_n = OP_WRITE;
			3'd1: sb_n = 8'((w_q.addr & ADDR_HI_MASK) >> 8);
			3'd2: sb_n = w_q.addr[7:0];
			default: begin
				sb_n = (ix_in || !rd_pend_q) ? rd_q : 8'd0;
				fe_n = (step_q - 3'd2 == w_q.size);
				last_n = fe_n;
			end
		endcase
	end

	assign emit = !ov_q || pop;
	// output register loads this cycle
	assign fire = emit && ((bs_q == BS_OUT) ||
		(bs_q == BS_FRAME && (step_q < 3'd3 || rd_pend_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q <= BS_IDLE;
			ov_q <= 1'b0;
			step_q <= '0;
			got_q <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			ov_q <= fire || (ov_q && !pop);
			unique case (bs_q)
				BS_IDLE: if (wq_valid) begin
					w_q <= wq_data;
					got_q <= '0;
					acc_q <= '0;
					rd_pend_q <= 1'b0;
					if (wq_data.opk == OPK_READ && wq_data.size == 3'd0) begin
						// rdsr byte, then dummy byte with frame end
						step_q <= 3'd1;
						bs_q <= BS_OUT;
					end else begin
						step_q <= '0;
						if (wq_data.opk == OPK_READ) bs_q <= BS_READ;
						else if (wq_data.opk == OPK_FRAME) bs_q <= BS_FRAME;
						else bs_q <= BS_OUT;
					end
				end
				BS_READ: begin
					// address issued last cycle, data in rd_q now
					if (rd_pend_q) begin
						acc_q <= {acc_q[23:0], rd_q};
						got_q <= got_q + 3'd1;
						rd_pend_q <= 1'b0;
						if (got_q + 3'd1 == w_q.size) begin
							w_q.opk <= OPK_RESULT;
							bs_q <= BS_OUT;
						end
					end else rd_pend_q <= 1'b1;
				end
				BS_FRAME: begin
					if (step_q < 3'd3) begin
						if (emit) begin
							kind <= KIND_SPI; rdata <= '0; status <= ST_OK;
							spi_byte <= sb_n; frame_end <= 1'b0; last <= 1'b0;
							step_q <= step_q + 3'd1;
						end
					end else if (!rd_pend_q) rd_pend_q <= 1'b1;
					else if (emit) begin
						kind <= KIND_SPI; rdata <= '0; status <= ST_OK;
						spi_byte <= ix_in ? rd_q : 8'd0;
						frame_end <= fe_n; last <= last_n;
						rd_pend_q <= 1'b0;
						got_q <= got_q + 3'd1;
						step_q <= step_q + 3'd1;
						if (fe_n) bs_q <= BS_IDLE;
					end
				end
				BS_OUT: if (emit) begin
					kind <= w_q.kind;
					rdata <= (w_q.kind == KIND_RDATA) ? acc_q : 32'd0;
					status <= w_q.status;
					if (step_q == 3'd2) begin
						// dummy byte that closes the rdsr frame
						spi_byte <= 8'd0;
						frame_end <= 1'b1;
						last <= 1'b1;
					end else begin
						spi_byte <= w_q.spi_byte;
						frame_end <= w_q.frame_end;
						last <= w_q.last;
					end
					if (step_q == 3'd1) step_q <= 3'd2;
					else bs_q <= BS_IDLE;
				end
				default: bs_q <= BS_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== hdl/spi_eeprom_write_behind_controller_core.sv =====
// top level: front end, work queue and back end of the write-behind controller
// a write frame gives 3 header bytes, then its data bytes read from the shadow
// input waits while shadow bytes are being written, while work is queued and while
// the shadow is being read for a read or a frame
// reset clears queue pointers and phase; shadow and job slots hold garbage until written
`timescale 1ns / 1ps
`default_nettype none
`include "spi_eeprom_write_behind_controller_core_macros.svh"
module spi_eeprom_write_behind_controller_core #(
	parameter int MEM_BYTES = sewb_pkg::MEM_BYTES_DEF,
	parameter int QUEUE_DEPTH = sewb_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic full,
	input  wire logic [2:0] cmd,
	input  wire logic [9:0] addr,
	input  wire logic [2:0] size,
	input  wire logic [31:0] wdata,
	input  wire logic [7:0] status_in,
	output logic empty,
	input  wire logic pop,
	output logic [1:0] kind,
	output logic [31:0] rdata,
	output logic [7:0] spi_byte,
	output logic frame_end,
	output logic [1:0] status,
	output logic last
);
	import sewb_pkg::*;
	localparam int AW = $clog2(MEM_BYTES);

	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0] wr_data;
	logic wq_push, wq_full, wq_valid, wq_pop;
	logic rd_busy;
	work_t wq_in, wq_out;

	sewb_front #(.MEM_BYTES(MEM_BYTES), .QUEUE_DEPTH(QUEUE_DEPTH), .AW(AW)) u_front (
		.clk, .arst_n, .push, .full, .cmd, .addr, .size, .wdata, .status_in,
		.wr_en, .wr_addr, .wr_data, .wq_push, .wq_data(wq_in), .wq_full,
		.wq_busy(wq_valid), .back_busy(rd_busy)
	);

	sewb_wq #(.DEPTH(4)) u_wq (
		.clk, .arst_n, .in_push(wq_push), .in_data(wq_in), .in_full(wq_full),
		.out_valid(wq_valid), .out_data(wq_out), .out_pop(wq_pop)
	);

	sewb_back #(.MEM_BYTES(MEM_BYTES), .AW(AW)) u_back (
		.clk, .arst_n, .wr_en, .wr_addr, .wr_data, .wq_valid, .wq_data(wq_out),
		.wq_pop, .rd_busy, .empty, .pop, .kind, .rdata, .spi_byte, .frame_end, .status,
		.last
	);

	`SEWB_ASSERT_IMP(a_fe_spi, clk, arst_n, !empty && frame_end, kind == KIND_SPI)
	`SEWB_ASSERT_IMP(a_rdata_kind, clk, arst_n, !empty && rdata != 32'd0, kind == KIND_RDATA)
	`SEWB_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(spi_byte))
endmodule
`default_nettype wire

// ===== tb/tb_spi_eeprom_write_behind_controller_core.sv =====
// self-checking testbench for the spi eeprom write-behind controller core
`timescale 1ns / 1ps
`default_nettype none
module tb_spi_eeprom_write_behind_controller_core;
	import sewb_pkg::*;

	localparam int MEMB = MEM_BYTES_DEF;
	localparam int QDEPTH = QUEUE_DEPTH_DEF;

	typedef enum logic [2:0] {
		FL_IDLE, FL_WREN, FL_WRITE, FL_WAIT, FL_POLL
	} flush_t;

	typedef struct {
		logic [2:0]  cmd;
		logic [9:0]  addr;
		logic [2:0]  size;
		logic [31:0] wdata;
		logic [7:0]  status_in;
		bit          pause;
	} stim_t;

	typedef struct {
		logic [1:0]  kind;
		logic [31:0] rdata;
		logic [7:0]  spi_byte;
		logic        frame_end;
		logic [1:0]  status;
		logic        last;
	} resp_t;

	class eeprom_scoreboard;
		logic [7:0] shadow [MEMB];
		logic [9:0] job_a [QDEPTH];
		logic [2:0] job_s [QDEPTH];
		logic [4:0] head, tail;
		flush_t     fl;
		resp_t      expected_q [$];
		int         errors;

		function new();
			head = 0;
			tail = 0;
			fl = FL_IDLE;
			errors = 0;
		endfunction

		function void add(logic [1:0] k, logic [31:0] rd, logic [7:0] sb, logic fe,
				logic [1:0] st);
			resp_t r;
			r.kind = k;
			r.rdata = rd;
			r.spi_byte = sb;
			r.frame_end = fe;
			r.status = st;
			r.last = 1'b0;
			expected_q.push_back(r);
		endfunction

		function int count();
			return (int'(head) + 2 * QDEPTH - int'(tail)) % (2 * QDEPTH);
		endfunction

		// predict the results of one accepted transaction
		function void note(stim_t t);
			int n_prior;
			int s;
			bit fits;
			logic [31:0] r;
			logic [9:0] ja;
			int js;
			n_prior = expected_q.size();
			s = int'(t.size);
			fits = (s == 1 || s == 2 || s == 4) && (int'(t.addr) + s <= MEMB);
			case (t.cmd)
				CMD_READ: begin
					r = 0;
					if (fits)
						for (int i = 0; i < s; i++)
							r = (r << 8) | shadow[int'(t.addr) + i];
					add(KIND_RDATA, r, 8'h00, 1'b0, fits ? ST_OK : ST_RANGE);
				end
				CMD_WRITE: begin
					if (!fits) begin
						add(KIND_ACK, 0, 8'h00, 1'b0, ST_RANGE);
					end else begin
						for (int i = 0; i < s; i++)
							shadow[int'(t.addr) + i] = t.wdata[8 * (s - 1 - i) +: 8];
						if (count() >= QDEPTH) begin
							add(KIND_ACK, 0, 8'h00, 1'b0, ST_FULL);
						end else begin
							job_a[head % QDEPTH] = t.addr;
							job_s[head % QDEPTH] = t.size;
							head = 5'((int'(head) + 1) % (2 * QDEPTH));
							add(KIND_ACK, 0, 8'h00, 1'b0, ST_OK);
						end
					end
				end
				CMD_TICK: begin
					if (fl == FL_IDLE && count() != 0) begin
						fl = FL_WREN;
						add(KIND_SPI, 0, OP_WREN, 1'b1, ST_OK);
					end else if (fl == FL_WAIT) begin
						fl = FL_POLL;
						add(KIND_SPI, 0, OP_RDSR, 1'b0, ST_OK);
						add(KIND_SPI, 0, 8'h00, 1'b1, ST_OK);
					end
				end
				CMD_DONE: begin
					if (fl == FL_WREN) begin
						ja = job_a[tail % QDEPTH];
						js = int'(job_s[tail % QDEPTH]);
						fl = FL_WRITE;
						add(KIND_SPI, 0, OP_WRITE, 1'b0, ST_OK);
						add(KIND_SPI, 0, 8'({6'd0, ja} >> 8), 1'b0, ST_OK);
						add(KIND_SPI, 0, ja[7:0], 1'b0, ST_OK);
						for (int i = 0; i < js; i++)
							add(KIND_SPI, 0, shadow[int'(ja) + i], i + 1 == js, ST_OK);
					end else if (fl == FL_WRITE) begin
						fl = FL_WAIT;
					end else if (fl == FL_POLL) begin
						if ((t.status_in & WIP_MASK) == 0) begin
							fl = FL_IDLE;
							tail = 5'((int'(tail) + 1) % (2 * QDEPTH));
						end else begin
							fl = FL_WAIT;
						end
					end
				end
				CMD_PRELOAD: begin
					if (int'(t.addr) < MEMB) begin
						shadow[t.addr] = t.wdata[7:0];
						add(KIND_ACK, 0, 8'h00, 1'b0, ST_OK);
					end else begin
						add(KIND_ACK, 0, 8'h00, 1'b0, ST_RANGE);
					end
				end
				default: ;
			endcase
			if (expected_q.size() > n_prior)
				expected_q[expected_q.size() - 1].last = 1'b1;
		endfunction

		function void check(resp_t a);
			resp_t e;
			if (expected_q.size() == 0) begin
				$error("unexpected result kind=%0d spi_byte=%h", a.kind, a.spi_byte);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (a.kind !== e.kind) begin
				$error("kind: expected %0d actual %0d", e.kind, a.kind); errors++;
			end
			if (a.rdata !== e.rdata) begin
				$error("rdata: expected %h actual %h", e.rdata, a.rdata); errors++;
			end
			if (a.spi_byte !== e.spi_byte) begin
				$error("spi_byte: expected %h actual %h", e.spi_byte, a.spi_byte); errors++;
			end
			if (a.frame_end !== e.frame_end) begin
				$error("frame_end: expected %0d actual %0d", e.frame_end, a.frame_end);
				errors++;
			end
			if (a.status !== e.status) begin
				$error("status: expected %0d actual %0d", e.status, a.status); errors++;
			end
			if (a.last !== e.last) begin
				$error("last: expected %0d actual %0d", e.last, a.last); errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic [2:0] cmd = '0;
	logic [9:0] addr = '0;
	logic [2:0] size = '0;
	logic [31:0] wdata = '0;
	logic [7:0] status_in = '0;
	logic pop = 1'b0;
	logic full, empty, frame_end, last;
	logic [1:0] kind, status;
	logic [31:0] rdata;
	logic [7:0] spi_byte;

	spi_eeprom_write_behind_controller_core uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.cmd(cmd), .addr(addr), .size(size), .wdata(wdata), .status_in(status_in),
		.empty(empty), .pop(pop), .kind(kind), .rdata(rdata), .spi_byte(spi_byte),
		.frame_end(frame_end), .status(status), .last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	eeprom_scoreboard sb = new();
	stim_t items [$];
	// regions of the shadow known to hold data, so reads never touch garbage
	logic [9:0] known_a [$];
	int known_s [$];
	bit sender_done = 0;

	task automatic add_item(logic [2:0] c, logic [9:0] a, logic [2:0] s, logic [31:0] d,
			logic [7:0] si);
		stim_t t;
		t.cmd = c;
		t.addr = a;
		t.size = s;
		t.wdata = d;
		t.status_in = si;
		t.pause = 0;
		if ((c == CMD_WRITE && (s == 1 || s == 2 || s == 4) && int'(a) + int'(s) <= MEMB)
				|| c == CMD_PRELOAD) begin
			known_a.push_back(a);
			known_s.push_back(c == CMD_PRELOAD ? 1 : int'(s));
		end
		items.push_back(t);
	endtask

	task automatic add_pause();
		stim_t t;
		t = '{default: 0};
		t.pause = 1;
		items.push_back(t);
	endtask

	task automatic add_safe_read();
		int k, s, off;
		logic [2:0] sz;
		k = $urandom_range(0, known_a.size() - 1);
		do begin
			sz = 3'(1 << $urandom_range(0, 2));
		end while (int'(sz) > known_s[k]);
		s = int'(sz);
		off = $urandom_range(0, known_s[k] - s);
		add_item(CMD_READ, 10'(int'(known_a[k]) + off), sz, $urandom, 8'($urandom));
	endtask

	task automatic build_stimulus();
		int pick;
		logic [2:0] sz;
		// corners and special cases
		add_item(CMD_PRELOAD, 10'd0, 3'd0, 32'hFFFF_FFAB, 8'h00);
		add_item(CMD_PRELOAD, 10'd1023, 3'd7, 32'h0000_0000, 8'hFF);
		add_item(CMD_WRITE, 10'd0, 3'd4, 32'hFFFF_FFFF, 8'h00);
		add_item(CMD_WRITE, 10'd1020, 3'd4, 32'h1234_5678, 8'h00);
		add_item(CMD_WRITE, 10'd1022, 3'd4, 32'hDEAD_BEEF, 8'h00);
		add_item(CMD_WRITE, 10'd8, 3'd3, 32'hAAAA_5555, 8'h00);
		add_item(CMD_WRITE, 10'd1023, 3'd1, 32'h0000_00C3, 8'h00);
		add_item(CMD_READ, 10'd0, 3'd4, 32'h0, 8'h00);
		add_item(CMD_READ, 10'd1022, 3'd2, 32'h0, 8'h00);
		add_item(CMD_READ, 10'd1021, 3'd4, 32'h0, 8'h00);
		add_item(CMD_READ, 10'd4, 3'd0, 32'h0, 8'h00);
		add_item(CMD_READ, 10'd4, 3'd7, 32'h0, 8'h00);
		add_item(CMD_DONE, 10'd0, 3'd0, 32'h0, 8'h00);
		add_item(CMD_TICK, 10'd0, 3'd0, 32'h0, 8'h00);
		add_item(CMD_TICK, 10'd0, 3'd0, 32'h0, 8'h00);
		add_item(CMD_DONE, 10'd0, 3'd0, 32'h0, 8'h00);
		add_item(CMD_DONE, 10'd0, 3'd0, 32'h0, 8'h00);
		add_item(CMD_DONE, 10'd0, 3'd0, 32'h0, 8'h00);
		add_item(CMD_TICK, 10'd0, 3'd0, 32'h0, 8'h00);
		add_item(CMD_DONE, 10'd0, 3'd0, 32'h0, 8'hFF);
		add_item(CMD_TICK, 10'd0, 3'd0, 32'h0, 8'h00);
		add_item(CMD_DONE, 10'd0, 3'd0, 32'h0, 8'hFE);
		add_item(3'd5, 10'h3FF, 3'd7, 32'hFFFF_FFFF, 8'hFF);
		add_item(3'd6, 10'd0, 3'd0, 32'h0, 8'h00);
		add_item(3'd7, 10'd0, 3'd0, 32'h0, 8'h00);
		add_pause();
		for (int n = 0; n < 250; n++) begin
			if (n == 125)
				add_pause();
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				// overfill the job ring
				for (int j = 0; j < QDEPTH + 2; j++)
					add_item(CMD_WRITE, 10'($urandom), 3'(1 << $urandom_range(0, 2)),
						$urandom, 8'($urandom));
			end else if (pick < 25) begin
				sz = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'(1 << $urandom_range(0, 2));
				add_item(CMD_WRITE, 10'($urandom), sz, $urandom, 8'($urandom));
			end else if (pick < 33) begin
				add_item(CMD_PRELOAD, 10'($urandom), 3'($urandom), $urandom, 8'($urandom));
			end else if (pick < 47) begin
				add_safe_read();
			end else if (pick < 50) begin
				// bad size or past the end
				if ($urandom_range(0, 1))
					add_item(CMD_READ, 10'($urandom), 3'($urandom_range(0, 1) ? 0 : 3 + 2 *
						$urandom_range(0, 2)), $urandom, 8'($urandom));
				else
					add_item(CMD_READ, 10'($urandom_range(1021, 1023)), 3'd4, $urandom,
						8'($urandom));
			end else if (pick < 72) begin
				add_item(CMD_TICK, 10'($urandom), 3'($urandom), $urandom, 8'($urandom));
			end else if (pick < 97) begin
				add_item(CMD_DONE, 10'($urandom), 3'($urandom), $urandom, 8'($urandom));
			end else begin
				add_item(3'($urandom_range(5, 7)), 10'($urandom), 3'($urandom), $urandom,
					8'($urandom));
			end
		end
	endtask

	initial begin
		stim_t cur;
		int idx, burst, gap;
		build_stimulus();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		idx = 0;
		burst = $urandom_range(1, 12);
		gap = 0;
		while (1) begin
			@(posedge clk);
			if (push && !full)
				sb.note(cur);
			if (!(push && full)) begin
				if (gap > 0) begin
					gap--;
					push <= 1'b0;
				end else if (idx == items.size()) begin
					push <= 1'b0;
					break;
				end else if (items[idx].pause) begin
					push <= 1'b0;
					if (sb.expected_q.size() == 0 && !(push && !full))
						idx++;
				end else begin
					cur = items[idx];
					idx++;
					cmd <= cur.cmd;
					addr <= cur.addr;
					size <= cur.size;
					wdata <= cur.wdata;
					status_in <= cur.status_in;
					push <= 1'b1;
					burst--;
					if (burst == 0) begin
						burst = $urandom_range(1, 20);
						gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
					end
				end
			end
		end
		sender_done = 1;
	end

	// receiver: cycles through free flow, random stalls and a periodic stall pattern
	int rx_cycle = 0;
	always @(posedge clk) begin
		resp_t a;
		if (pop && !empty) begin
			a.kind = kind;
			a.rdata = rdata;
			a.spi_byte = spi_byte;
			a.frame_end = frame_end;
			a.status = status;
			a.last = last;
			sb.check(a);
		end
		rx_cycle <= rx_cycle + 1;
		if ((rx_cycle / 150) % 3 == 0)
			pop <= 1'b1;
		else if ((rx_cycle / 150) % 3 == 1)
			pop <= ($urandom_range(0, 3) == 0);
		else
			pop <= ((rx_cycle % 7) < 3);
	end

	initial begin
		wait (sender_done);
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("spi_eeprom_write_behind_controller_core verification clean");
		else
			$display("spi_eeprom_write_behind_controller_core verification failed");
		$finish;
	end

	initial begin
		#3000000;
		$display("spi_eeprom_write_behind_controller_core verification failed");
		$finish;
	end
endmodule
`default_nettype wire

// ===== spi_eeprom_write_behind_controller_core.f =====
+incdir+hdl
hdl/sewb_pkg.sv
hdl/sewb_front.sv
hdl/sewb_wq.sv
hdl/sewb_back.sv
hdl/spi_eeprom_write_behind_controller_core.sv
tb/tb_spi_eeprom_write_behind_controller_core.sv
